// File: rtl/core/assert_macros.svh
// assertion macros for the indexed list rtl
// no dependencies; taken in by iidl_ctrl, the file that carries assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/iidl_pkg.sv
// types and constants for the indexed insert/delete list
// no dependencies
package iidl_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int POS_W             = 7;
    localparam int DATA_W            = 32;
    localparam int COUNT_W           = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  write_data;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  read_data;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // command broadcast along the cell row
    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   position;
    } cell_cmd_t;

endpackage

// File: rtl/core/iidl_stream_if.sv
// valid/ready channel carrying one item payload
// no dependencies; payload type set per instance
interface iidl_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// File: rtl/core/iidl_cell.sv
// one list slot: holds an entry and shifts with its neighbors
// depends on iidl_pkg
module iidl_cell #(
    parameter int CAPACITY      = iidl_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = iidl_pkg::ELEMENT_WIDTH_DEF,
    parameter int INDEX         = 0
) (
    input  logic                     clk,
    input  iidl_pkg::cell_cmd_t      cmd,
    input  logic [ELEMENT_WIDTH-1:0] left_data,
    input  logic [ELEMENT_WIDTH-1:0] right_data,
    input  logic [ELEMENT_WIDTH-1:0] write_data,
    output logic [ELEMENT_WIDTH-1:0] data
);
    import iidl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [ELEMENT_WIDTH-1:0] data_reg;
    logic [ELEMENT_WIDTH-1:0] data_next;
    logic [CMP_W-1:0]         index_ext;
    logic [CMP_W-1:0]         pos_ext;

    assign index_ext = CMP_W'(INDEX);
    assign pos_ext   = CMP_W'(cmd.position);

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (index_ext > pos_ext)
                begin
                    data_next = left_data;
                end
                else if (index_ext == pos_ext)
                begin
                    data_next = write_data;
                end
            end
            OP_DELETE:
            begin
                if (index_ext >= pos_ext)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/core/iidl_ctrl.sv
// request decode, count register, range checks and result register
// depends on iidl_pkg, iidl_stream_if and assert_macros.svh
`include "assert_macros.svh"
module iidl_ctrl #(
    parameter int CAPACITY      = iidl_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = iidl_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    iidl_stream_if.sink              req,
    iidl_stream_if.source            rsp,
    input  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY],
    output iidl_pkg::cell_cmd_t      cmd,
    output logic [ELEMENT_WIDTH-1:0] write_data
);
    import iidl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             accept;
    cell_cmd_t        cmd_raw;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cap_ext;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] count_upd;

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;
    assign pos_ext    = CMP_W'(req.payload.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign cap_ext    = CMP_W'(CAPACITY);
    // only used when position is below count, so it fits the row
    assign rd_idx     = IDX_W'(req.payload.position);
    assign write_data = ELEMENT_WIDTH'(req.payload.write_data);

    always_comb
    begin
        rsp_next.status    = ST_OK;
        rsp_next.read_data = '0;
        cmd_raw.op         = OP_HOLD;
        cmd_raw.position   = req.payload.position;
        count_upd          = count_reg;
        case (req.payload.req_type)
            REQ_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (cnt_ext == cap_ext)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    cmd_raw.op = OP_INSERT;
                    count_upd  = count_reg + 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    cmd_raw.op = OP_DELETE;
                    count_upd  = count_reg - 1'b1;
                end
            end
            REQ_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.read_data = DATA_W'(cell_data[rd_idx]);
                end
            end
            REQ_CLEAR:
            begin
                count_upd = '0;
            end
            default:
            begin
                count_upd = count_reg;
            end
        endcase
        rsp_next.count = COUNT_W'(count_upd);
    end

    // nothing moves unless the item is taken
    always_comb
    begin
        cmd            = cmd_raw;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (accept)
        begin
            count_next     = count_upd;
            rsp_valid_next = 1'b1;
        end
        else
        begin
            cmd.op = OP_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    `ASSERT_PROP(a_count_cap, clk, rst_n, CMP_W'(count_reg) <= cap_ext)
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && req.payload.req_type == REQ_CLEAR, count_reg == '0)
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && cmd.op == OP_INSERT, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `ASSERT_NEXT(a_rdata_zero, clk, rst_n, accept && req.payload.req_type != REQ_GET, rsp_reg.read_data == '0)

endmodule

// File: rtl/core/indexed_insert_delete_list.sv
// top level of the indexed insert/delete list: control plus a row of cells
// depends on iidl_pkg, iidl_stream_if, iidl_cell and iidl_ctrl
//
//   channel  dir  payload                           handshake
//   req      in   req_type, position, write_data    valid/ready
//   rsp      out  status, read_data, count          valid/ready
//
// one item per cycle while the sink takes results: an accepted item shifts the whole
// cell row in a single step and its result sits in the output register from the next cycle on
// the row step and the get mux over the cells set the cycle time
// reset clears the count and the output valid; the entries keep garbage
// and are never read before being written
// a result left waiting holds off the input until the sink takes it; the
// result can leave and a new item come in during the same cycle
module indexed_insert_delete_list #(
    parameter int CAPACITY      = iidl_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = iidl_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    iidl_stream_if.sink   req,
    iidl_stream_if.source rsp
);
    import iidl_pkg::*;

    // entries held by the row, one per cell
    logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
    // shift command broadcast to every cell
    cell_cmd_t                cmd;
    // new element, already cut to the element width
    logic [ELEMENT_WIDTH-1:0] write_data;

    iidl_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cell_data  (cell_data),
        .cmd        (cmd),
        .write_data (write_data)
    );

    // each cell sees its lower neighbor for insert and upper one for delete
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_data;
        logic [ELEMENT_WIDTH-1:0] right_data;

        if (g == 0)
        begin : g_first
            // never shifted into from below
            assign left_data = '0;
        end
        else
        begin : g_mid_left
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            // top slot is past the count after any delete
            assign right_data = cell_data[g];
        end
        else
        begin : g_mid_right
            assign right_data = cell_data[g+1];
        end

        iidl_cell #(
            .CAPACITY      (CAPACITY),
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .INDEX         (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .write_data (write_data),
            .data       (cell_data[g])
        );
    end

endmodule

// File: dv/tb.sv
// self-checking bench for indexed_insert_delete_list: directed and random requests
// depends on iidl_pkg, iidl_stream_if and the rtl of indexed_insert_delete_list
`timescale 1ns / 100ps

module tb;

    import iidl_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam logic [DATA_W-1:0] ELEM_MASK = {DATA_W{1'b1}} >> (DATA_W - ELEMENT_WIDTH_DEF);
    localparam int RAND_ITEMS = 400;

    // kinds of random burst, each leaning toward a different list shape
    typedef enum int {
        BURST_GROW,
        BURST_SHRINK,
        BURST_MIX,
        BURST_FILL
    } burst_kind_t;

    logic clk;
    logic rst_n;

    iidl_stream_if #(.PAYLOAD_T(req_t)) req_if ();
    iidl_stream_if #(.PAYLOAD_T(rsp_t)) rsp_if ();

    indexed_insert_delete_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // shadow list used to predict every response
    logic [DATA_W-1:0] list_mem [LIST_CAP];
    int                list_len = 0;

    // items waiting to be driven and responses still owed by the block
    req_t req_backlog [$];
    rsp_t due_rsps [$];

    // length the list will have once all generated items are applied
    int gen_len = 0;
    int rand_items = 0;

    int  errors = 0;
    int  rsp_seen = 0;
    bit  req_taken = 1'b0;
    bit  long_hold = 1'b0;
    int  req_gap = 0;
    int  req_calm = 0;
    int  rsp_wait = 0;
    int  rsp_calm = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // apply one request to the shadow list and return the response it owes
    function automatic rsp_t list_step(req_t rq);
        rsp_t rs;
        int   p;
        rs.status    = ST_OK;
        rs.read_data = '0;
        p            = rq.position;
        case (rq.req_type)
            REQ_INSERT:
            begin
                // the range check wins over the full check
                if (p > list_len)
                    rs.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    rs.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = rq.write_data & ELEM_MASK;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (p >= list_len)
                    rs.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            REQ_GET:
            begin
                if (p >= list_len)
                    rs.status = ST_RANGE;
                else
                    rs.read_data = list_mem[p] & ELEM_MASK;
            end
            default:
                list_len = 0;
        endcase
        rs.count = COUNT_W'(list_len);
        return rs;
    endfunction

    // queue an item for the driver and track the list length it leads to
    task automatic push_req(req_type_t t, int pos, logic [DATA_W-1:0] d);
        req_t rq;
        rq.req_type   = t;
        rq.position   = POS_W'(pos);
        rq.write_data = d;
        req_backlog.push_back(rq);
        case (t)
            REQ_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
            REQ_DELETE: if (pos < gen_len) gen_len--;
            REQ_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    // element values, with all-zero and all-one words showing up often
    function automatic logic [DATA_W-1:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // position for an item: mostly legal, sometimes an end point, sometimes out of range
    function automatic int pick_pos(req_type_t t, bit noisy);
        int top;
        int unsigned r;
        top = (t == REQ_INSERT) ? gen_len : gen_len - 1;
        if (noisy || top < 0)
        begin
            if (top + 1 <= 64)
                return $urandom_range(top + 1, 64);
            return $urandom_range(0, 64);
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return top;
        return $urandom_range(0, top);
    endfunction

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all
    function automatic int pick_gap(inout int calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 60);
            return 0;
        end
        else if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random bursts: each burst leans toward growing, shrinking or mixing,
    // and fill bursts, at least one per run, drive the list to capacity and poke at the top end
    task automatic build_random();
        burst_kind_t kind;
        int          blen;
        int          start_size;
        int unsigned r;
        int          ins_pct;
        int          del_pct;
        int          get_pct;
        bit          filled;
        req_type_t   op;
        filled = 1'b0;
        while (rand_items < RAND_ITEMS)
        begin
            start_size = req_backlog.size();
            r = $urandom_range(0, 9);
            kind = (r < 4) ? BURST_GROW : (r < 7) ? BURST_SHRINK :
                   (r < 9) ? BURST_MIX : BURST_FILL;
            if (!filled && rand_items > 100)
                kind = BURST_FILL;
            if (kind == BURST_FILL)
            begin
                filled = 1'b1;
                while (gen_len < LIST_CAP)
                    push_req(REQ_INSERT, pick_pos(REQ_INSERT, 1'b0), rand_word());
                // full list: insert at end and front, get top and past it, delete and refill top
                push_req(REQ_INSERT, LIST_CAP, rand_word());
                push_req(REQ_INSERT, 0, rand_word());
                push_req(REQ_GET, LIST_CAP - 1, '0);
                push_req(REQ_GET, LIST_CAP, '0);
                push_req(REQ_DELETE, LIST_CAP - 1, '0);
                push_req(REQ_INSERT, LIST_CAP - 1, rand_word());
                push_req(REQ_GET, LIST_CAP - 1, '0);
                for (int k = 0; k < 12; k++)
                    push_req(REQ_GET, pick_pos(REQ_GET, 1'b0), '0);
            end
            else
            begin
                case (kind)
                    BURST_GROW:   begin ins_pct = 70; del_pct = 10; get_pct = 19; end
                    BURST_SHRINK: begin ins_pct = 15; del_pct = 60; get_pct = 24; end
                    default:      begin ins_pct = 35; del_pct = 30; get_pct = 33; end
                endcase
                blen = $urandom_range(8, 40);
                for (int k = 0; k < blen; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct)
                        op = REQ_INSERT;
                    else if (r < ins_pct + del_pct)
                        op = REQ_DELETE;
                    else if (r < ins_pct + del_pct + get_pct)
                        op = REQ_GET;
                    else
                        op = REQ_CLEAR;
                    push_req(op, pick_pos(op, $urandom_range(0, 9) == 0),
                             (op == REQ_INSERT) ? rand_word() : $urandom);
                end
            end
            rand_items += req_backlog.size() - start_size;
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        rst_n          = 1'b0;

        // directed: empty-list errors, insert beyond count, position with bit 6 set
        push_req(REQ_GET, 0, '0);
        push_req(REQ_DELETE, 0, '0);
        push_req(REQ_INSERT, 1, 32'h1234_5678);
        push_req(REQ_INSERT, 64, 32'hDEAD_BEEF);
        // build a short list through front, end and middle inserts
        push_req(REQ_INSERT, 0, 32'hFFFF_FFFF);
        push_req(REQ_INSERT, 0, 32'h0000_0000);
        push_req(REQ_INSERT, 2, 32'hA5A5_A5A5);
        push_req(REQ_INSERT, 1, 32'h5A5A_5A5A);
        push_req(REQ_GET, 0, '1);
        push_req(REQ_GET, 3, '0);
        push_req(REQ_GET, 4, '0);
        push_req(REQ_GET, 64, '0);
        // middle delete, last delete, delete at count, front delete
        push_req(REQ_DELETE, 1, '1);
        push_req(REQ_GET, 1, '0);
        push_req(REQ_DELETE, 2, '0);
        push_req(REQ_DELETE, 2, '0);
        push_req(REQ_DELETE, 0, '0);
        push_req(REQ_GET, 0, '0);
        // clear leaves stale entries that must not be readable
        push_req(REQ_CLEAR, 0, '0);
        push_req(REQ_GET, 0, '0);
        push_req(REQ_CLEAR, 127, '1);
        push_req(REQ_INSERT, 0, 32'h8000_0001);
        push_req(REQ_GET, 0, '0);

        build_random();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything offered and taken, then every response back
        while (req_backlog.size() > 0 || req_if.valid)
            @(posedge clk);
        while (due_rsps.size() > 0)
            @(posedge clk);
        // then wait on to catch a stray response
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("indexed_insert_delete_list: match");
        else
            $display("indexed_insert_delete_list: mismatch");
        $finish;
    end

    // request driver: changes at the falling edge, holds an item until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_taken)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_if.valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                req_if.valid   <= 1'b1;
                req_if.payload <= req_backlog.pop_front();
                req_gap = pick_gap(req_calm);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // response side ready: random gaps plus the one long hold
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (rsp_wait > 0)
        begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= !long_hold;
            rsp_wait = pick_gap(rsp_calm);
        end
    end

    // long hold on the response side so the block backs up and stalls its input
    initial
    begin
        while (rsp_seen < 100)
            @(posedge clk);
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
    end

    // monitor: check responses in order, predict each accepted request
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        req_taken = rst_n && req_if.valid && req_if.ready;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            rsp_seen++;
            if (due_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: response with none outstanding: status %0d data %h count %0d",
                         $time, got.status, got.read_data, got.count);
            end
            else
            begin
                want = due_rsps.pop_front();
                if (got.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.read_data !== want.read_data)
                begin
                    errors++;
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, got.read_data);
                end
                if (got.count !== want.count)
                begin
                    errors++;
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, got.count);
                end
            end
        end
        // response comes in a later cycle, so predict after the check
        if (req_taken)
            due_rsps.push_back(list_step(req_if.payload));
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("indexed_insert_delete_list: mismatch");
        $finish;
    end

endmodule
